[rtl/core/assert_macros.svh]
// assertion macros shared by the core modules
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/lss_pkg.sv]
// widths, state encoding and status types of the slew limiter core
// no dependencies; imported by the interfaces and all core modules
package lss_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int TIME_W     = 16;
    localparam int RATE_W     = 18;
    localparam int MAG_W      = SAMPLE_W;
    localparam int FRAC_SHIFT = 8;
    localparam int NUM_W      = MAG_W + FRAC_SHIFT;
    localparam int DEN_W      = TIME_W + RATE_W;
    localparam int SUM_W      = NUM_W + 2;
    localparam int QCNT_W     = $clog2(NUM_W);

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_DIV,
        ST_APPLY
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[rtl/core/lss_in_if.sv]
// input item channel: sample and glide times with valid/ready
// depends on lss_pkg
interface lss_in_if import lss_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [TIME_W-1:0]          rise_time;
    logic [TIME_W-1:0]          fall_time;

    modport source (output valid, sample_in, rise_time, fall_time, input ready);
    modport sink   (input valid, sample_in, rise_time, fall_time, output ready);

endinterface

[rtl/core/lss_out_if.sv]
// result item channel: glided sample with valid/ready
// depends on lss_pkg
interface lss_out_if import lss_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink   (input valid, sample_out, output ready);

endinterface

[rtl/core/lss_cfg_if.sv]
// configuration write channel for the sample rate register
// depends on lss_pkg
interface lss_cfg_if import lss_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);

endinterface

[rtl/core/lss_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on lss_pkg and assert_macros.svh
module lss_div import lss_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic [NUM_W-1:0] o_quotient,
    output t_div_stat        o_stat
);

    localparam logic [QCNT_W-1:0] LAST_STEP = QCNT_W'(NUM_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [QCNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_div;
    logic [NUM_W-1:0]  r_quo;

    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_fits;
    logic [DEN_W-1:0]  n_rem;

    // shift next dividend bit into the partial remainder
    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_fits  = w_trial >= {1'b0, r_div};
    assign n_rem   = w_fits ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + QCNT_W'(1);
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend bits leave at the top, quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[NUM_W-2:0], w_fits};
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

`include "assert_macros.svh"

    `ASSERT_IMPL(a_rem_below_div, i_clk, i_rst_n, r_busy, r_rem < r_div, "remainder not below divisor")
    `ASSERT_NEXT(a_done_single, i_clk, i_rst_n, r_done, !r_done, "done held longer than one cycle")

endmodule

[rtl/core/linear_slide_slew_limiter_core.sv]
// linear glide slew limiter, top level with control sequencer and output register
// depends on lss_pkg, the lss_*_if interfaces, lss_div and assert_macros.svh
//
// Each input item carries a Q8.16 sample and rise/fall glide times in Q8.8 seconds;
// each item gives exactly one result item. When the sample differs from the current
// target a new glide starts from the last output. A selected time of zero passes the
// sample through; otherwise the output moves by (target-start)*256/(time*rate) per
// item, at least one LSB, clamped at the target. An item that needs a division goes
// through setup, multiply, the 32 steps of the bit-serial divider and write-back
// before the next item is accepted; an item with zero glide time or zero glide
// distance skips the divider. The result sits in an output register, so the next
// item is taken while a result still waits; a new result is written only once the
// previous one has left. The sample rate register resets to 48000 and a value of
// zero acts as one; write it only while the core is idle.
module linear_slide_slew_limiter_core import lss_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lss_in_if.sink       i_in,
    lss_out_if.source    o_out,
    lss_cfg_if.sink      i_cfg
);

    // control and glide state
    t_state            r_state;
    t_state            n_state;
    logic [RATE_W-1:0] r_rate;
    t_sample           r_start;
    t_sample           r_target;
    t_sample           r_prev;
    logic              r_out_valid;

    // per-item working registers
    t_sample           r_out_data;
    logic [TIME_W-1:0] r_rise;
    logic [TIME_W-1:0] r_fall;
    logic [TIME_W-1:0] r_time;
    logic [MAG_W-1:0]  r_mag;
    logic              r_rising;

    // sequencer outputs
    logic              w_in_ready;
    logic              w_div_start;
    logic              w_apply;

    logic              w_in_acc;
    logic              w_out_free;
    logic              w_rising;
    logic signed [SAMPLE_W:0]   w_diff;
    logic signed [SAMPLE_W:0]   w_abs;
    logic [RATE_W-1:0] w_rate;
    logic [DEN_W-1:0]  w_den;
    logic [NUM_W-1:0]  w_num;
    logic [NUM_W-1:0]  w_quo;
    t_div_stat         div_stat;
    logic [NUM_W-1:0]  w_qmag;
    logic signed [SUM_W-1:0] w_prev_x;
    logic signed [SUM_W-1:0] w_tgt_x;
    logic signed [SUM_W-1:0] w_q_x;
    logic signed [SUM_W-1:0] w_sum;
    t_sample           w_result;

    assign w_in_acc   = i_in.valid && w_in_ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // configuration: always ready, single register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (i_cfg.valid) begin
            r_rate <= i_cfg.data;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_apply     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in.valid) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                // jump and zero-distance glides need no division
                if (r_time == '0 || r_mag == '0) begin
                    n_state = ST_APPLY;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (w_out_free) begin
                    w_apply = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign i_in.ready = w_in_ready;

    // a changed sample restarts the glide from the last output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_target <= '0;
            r_prev   <= '0;
        end else begin
            if (w_in_acc && (i_in.sample_in != r_target)) begin
                r_start  <= r_prev;
                r_target <= i_in.sample_in;
            end
            if (w_apply) begin
                r_prev <= w_result;
            end
        end
    end

    // setup: direction, chosen time and glide distance
    assign w_rising = r_target > r_start;
    assign w_diff   = {r_target[SAMPLE_W-1], r_target} - {r_start[SAMPLE_W-1], r_start};
    assign w_abs    = w_diff[SAMPLE_W] ? -w_diff : w_diff;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_rise <= i_in.rise_time;
            r_fall <= i_in.fall_time;
        end
        if (r_state == ST_SETUP) begin
            r_rising <= w_rising;
            r_time   <= w_rising ? r_rise : r_fall;
            r_mag    <= w_abs[MAG_W-1:0];
        end
    end

    // divisor time*rate goes straight into the divider's register
    assign w_rate = (r_rate == '0) ? RATE_W'(1) : r_rate;
    assign w_den  = DEN_W'(r_time) * DEN_W'(w_rate);
    assign w_num  = {r_mag, {FRAC_SHIFT{1'b0}}};

    lss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_num),
        .i_divisor  (w_den),
        .o_quotient (w_quo),
        .o_stat     (div_stat)
    );

    // step of at least one LSB, zero when start equals target
    assign w_qmag   = (r_mag == '0) ? '0 : ((w_quo == '0) ? NUM_W'(1) : w_quo);
    assign w_prev_x = SUM_W'(r_prev);
    assign w_tgt_x  = SUM_W'(r_target);
    assign w_q_x    = $signed({{(SUM_W-NUM_W){1'b0}}, w_qmag});
    assign w_sum    = r_rising ? (w_prev_x + w_q_x) : (w_prev_x - w_q_x);

    always_comb begin
        if (r_time == '0) begin
            w_result = r_target;
        end else if ((r_rising && (w_sum > w_tgt_x)) || (!r_rising && (w_sum < w_tgt_x))) begin
            w_result = r_target;
        end else begin
            w_result = w_sum[SAMPLE_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_apply) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_out_data <= w_result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_data;

`include "assert_macros.svh"

    `ASSERT_IMPL(a_prev_in_span, i_clk, i_rst_n, r_state == ST_IDLE, (r_prev >= r_start && r_prev <= r_target) || (r_prev <= r_start && r_prev >= r_target), "output left the glide span")
    `ASSERT_IMPL(a_div_alive, i_clk, i_rst_n, r_state == ST_DIV, div_stat.busy || div_stat.done, "waiting on an idle divider")
    `ASSERT_NEXT(a_out_from_apply, i_clk, i_rst_n, !r_out_valid && r_state != ST_APPLY, !r_out_valid, "result appeared outside write-back")

endmodule

[tb/lss_glide_checker.sv]
// glide checker: watches the input, result and config channels of the slew limiter core
// predicts each result from its own copy of the glide state and compares in order
// depends on lss_pkg and the lss_in_if, lss_out_if and lss_cfg_if interfaces
module lss_glide_checker import lss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    lss_in_if    i_in,
    lss_out_if   i_out,
    lss_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [RATE_W-1:0] rate_q;
    t_sample           glide_start_q;
    t_sample           glide_target_q;
    t_sample           last_out_q;
    t_sample           expected_q[$];

    // advance the glide by one item and return the sample it should produce
    function automatic t_sample next_glide_sample(t_sample x, logic [TIME_W-1:0] up_t,
                                                  logic [TIME_W-1:0] down_t);
        logic              going_up;
        logic [TIME_W-1:0] sel_time;
        logic [RATE_W-1:0] eff_rate;
        longint            span;
        longint            mag;
        longint            denom;
        longint            quot;
        longint            stride;
        longint            nxt;
        if (x != glide_target_q) begin
            glide_start_q  = last_out_q;
            glide_target_q = x;
        end
        going_up = glide_target_q > glide_start_q;
        sel_time = going_up ? up_t : down_t;
        if (sel_time == '0) begin
            nxt = longint'(x);
        end else begin
            eff_rate = (rate_q == '0) ? RATE_W'(1) : rate_q;
            span     = longint'(glide_target_q) - longint'(glide_start_q);
            denom    = longint'(sel_time) * longint'(eff_rate);
            stride   = 0;
            if (span != 0) begin
                mag  = (span < 0) ? -span : span;
                quot = (mag << FRAC_SHIFT) / denom;
                if (quot == 0) begin
                    quot = 1;
                end
                stride = (span < 0) ? -quot : quot;
            end
            nxt = longint'(last_out_q) + stride;
            if ((going_up && nxt > longint'(glide_target_q)) ||
                (!going_up && nxt < longint'(glide_target_q))) begin
                nxt = longint'(glide_target_q);
            end
        end
        last_out_q = t_sample'(nxt);
        return last_out_q;
    endfunction

    always @(posedge i_clk) begin
        t_sample want;
        if (!i_rst_n) begin
            rate_q         = RATE_RESET;
            glide_start_q  = '0;
            glide_target_q = '0;
            last_out_q     = '0;
            expected_q.delete();
            o_fail_count   = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t glide check: result with none expected, actual %0d",
                             $time, i_out.sample_out);
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_out.sample_out !== want) begin
                        $display("%0t glide check: sample_out expected %0d, actual %0d",
                                 $time, want, i_out.sample_out);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                rate_q = i_cfg.data;
            end
            if (i_in.valid && i_in.ready) begin
                expected_q.push_back(next_glide_sample(i_in.sample_in, i_in.rise_time,
                                                       i_in.fall_time));
            end
        end
        o_pending = expected_q.size();
    end

endmodule

[tb/tb.sv]
// top of the slew limiter core testbench: clock, reset, stimulus and verdict
// depends on lss_pkg, the lss_*_if interfaces, linear_slide_slew_limiter_core
// and lss_glide_checker
module tb import lss_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam t_sample           SAMPLE_MAX = 24'sh7FFFFF;
    localparam t_sample           SAMPLE_MIN = 24'sh800000;
    localparam logic [TIME_W-1:0] TIME_MAX   = '1;
    localparam logic [RATE_W-1:0] RATE_MAX   = '1;
    localparam int unsigned       PHASE_ITEMS = 88;

    logic    i_clk;
    logic    i_rst_n;
    int      fail_count;
    int      pending;
    bit      gaps_on;
    bit      stalls_on;
    t_sample last_sample;

    lss_in_if  in_ch ();
    lss_out_if out_ch ();
    lss_cfg_if cfg_ch ();

    linear_slide_slew_limiter_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    lss_glide_checker u_glide_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // idle cycles before an item: mostly none or short, now and then long
    function automatic int unsigned sender_gap();
        int unsigned r;
        if (!gaps_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(11, 40);
    endfunction

    // glide times: zero (jump), short, medium, or anywhere in the field
    function automatic logic [TIME_W-1:0] pick_glide_time();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return '0;
        end else if (r < 70) begin
            return TIME_W'($urandom_range(1, 8));
        end else if (r < 85) begin
            return TIME_W'($urandom_range(9, 512));
        end
        return TIME_W'($urandom());
    endfunction

    // next glide target: near the last one so that glides finish, or far, or an extreme
    function automatic t_sample pick_target(t_sample from);
        int unsigned r;
        longint      delta;
        longint      v;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            delta = (r < 40) ? longint'($urandom_range(1, 64))
                             : longint'($urandom_range(1, 65536));
            if ($urandom_range(0, 1) == 1) begin
                delta = -delta;
            end
            v = longint'(from) + delta;
        end else if (r < 90) begin
            v = longint'(t_sample'($urandom()));
        end else begin
            case ($urandom_range(0, 2))
                0: v = longint'(SAMPLE_MAX);
                1: v = longint'(SAMPLE_MIN);
                default: v = 0;
            endcase
        end
        if (v > longint'(SAMPLE_MAX)) begin
            v = longint'(SAMPLE_MAX);
        end
        if (v < longint'(SAMPLE_MIN)) begin
            v = longint'(SAMPLE_MIN);
        end
        return t_sample'(v);
    endfunction

    // present one item and hold it until the core takes it; returns at a falling edge
    task automatic send_item(input t_sample smp, input logic [TIME_W-1:0] up_t,
                             input logic [TIME_W-1:0] down_t);
        int unsigned gap;
        gap = sender_gap();
        // drop valid only when a gap follows, so valid never toggles within one step
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= smp;
        in_ch.rise_time <= up_t;
        in_ch.fall_time <= down_t;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        last_sample = smp;
    endtask

    // a run of items that holds one target, so the output glides toward it;
    // the times change now and then in the middle of the glide
    task automatic send_glide_run(inout int unsigned left);
        t_sample           target;
        logic [TIME_W-1:0] up_t;
        logic [TIME_W-1:0] down_t;
        int unsigned       len;
        int unsigned       r;
        target = pick_target(last_sample);
        up_t   = pick_glide_time();
        down_t = pick_glide_time();
        r      = $urandom_range(0, 99);
        // single items act as noise that breaks off a glide early
        if (r < 15) begin
            len = 1;
        end else if (r < 85) begin
            len = $urandom_range(2, 12);
        end else begin
            len = $urandom_range(13, 40);
        end
        if (len > left) begin
            len = left;
        end
        repeat (len) begin
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1) == 1) begin
                    up_t = pick_glide_time();
                end else begin
                    down_t = pick_glide_time();
                end
            end
            send_item(target, up_t, down_t);
            left--;
        end
    endtask

    // sample rate write, only once every result is out and the core has settled
    task automatic write_rate(input logic [RATE_W-1:0] value);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // result side: ready stretches broken by stalls, mostly short, a few long
    initial begin
        int unsigned on_len;
        int unsigned off_len;
        int unsigned r;
        @(posedge i_rst_n);
        forever begin
            on_len = $urandom_range(1, 20);
            r      = $urandom_range(0, 99);
            if (!stalls_on) begin
                off_len = 0;
            end else if (r < 70) begin
                off_len = $urandom_range(1, 3);
            end else if (r < 95) begin
                off_len = $urandom_range(4, 12);
            end else begin
                off_len = $urandom_range(20, 60);
            end
            out_ch.ready <= 1'b1;
            repeat (on_len) @(negedge i_clk);
            if (off_len != 0) begin
                out_ch.ready <= 1'b0;
                repeat (off_len) @(negedge i_clk);
            end
        end
    end

    // main stimulus
    initial begin
        logic [RATE_W-1:0] rate;
        int unsigned       left;
        // every input known from time zero
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.sample_in  = '0;
        in_ch.rise_time  = '0;
        in_ch.fall_time  = '0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        gaps_on          = 1'b1;
        stalls_on        = 1'b1;
        last_sample      = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed items at the reset sample rate
        // start equals target: step is zero, output holds at zero
        send_item(24'sd0, 16'd7, 16'd7);
        // zero times jump straight to the extremes
        send_item(SAMPLE_MAX, 16'd0, 16'd9);
        send_item(SAMPLE_MIN, 16'd9, 16'd0);
        // full-scale upward glide, big steps, then the longest rise time
        send_item(SAMPLE_MAX, 16'd1, 16'd1);
        send_item(SAMPLE_MAX, 16'd1, 16'd1);
        send_item(SAMPLE_MAX, TIME_MAX, TIME_MAX);
        send_item(SAMPLE_MAX, TIME_MAX, 16'd0);
        // rise time dropped to zero mid-glide: lands on the target
        send_item(SAMPLE_MAX, 16'd0, TIME_MAX);
        send_item(SAMPLE_MAX, 16'd3, 16'd3);
        // step truncates to zero, at least one lsb downward
        send_item(-24'sd1, TIME_MAX, TIME_MAX);
        send_item(-24'sd1, TIME_MAX, 16'h8000);
        send_item(24'sd0, 16'd0, 16'd0);
        // alternating bit patterns on every field
        send_item(24'shAAAAAA, 16'h5555, 16'hAAAA);
        send_item(24'sh555555, 16'hAAAA, 16'h5555);

        // zero sample rate acts as one, which makes steps large and overshoot likely
        in_ch.valid <= 1'b0;
        write_rate('0);
        send_item(24'sd0, 16'd0, 16'd0);
        send_item(24'sd3, 16'd2, 16'd2);
        send_item(24'sd1003, 16'd300, 16'd300);
        send_item(24'sd1003, 16'd300, 16'd300);
        send_item(SAMPLE_MIN, 16'd1, TIME_MAX);
        send_item(SAMPLE_MIN, 16'd1, 16'd1);
        send_item(SAMPLE_MAX, 16'd1, 16'd1);
        send_item(SAMPLE_MAX, 16'h8000, 16'h8000);
        in_ch.valid <= 1'b0;

        // random glide runs over several sample rates, extremes among them
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: rate = RATE_W'(1000);
                1: rate = RATE_MAX;
                2: rate = RATE_W'(192000);
                3: rate = RATE_W'(1);
                4: rate = RATE_W'($urandom_range(1000, 192000));
                default: rate = RATE_W'($urandom());
            endcase
            // one phase runs back to back on both sides
            gaps_on   = (p != 2);
            stalls_on = (p != 2);
            write_rate(rate);
            left = PHASE_ITEMS;
            while (left != 0) begin
                send_glide_run(left);
            end
            in_ch.valid <= 1'b0;
        end

        // drain, then give stray results time to show up
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/lss_pkg.sv
rtl/core/lss_in_if.sv
rtl/core/lss_out_if.sv
rtl/core/lss_cfg_if.sv
rtl/core/lss_div.sv
rtl/core/linear_slide_slew_limiter_core.sv
tb/lss_glide_checker.sv
tb/tb.sv
